// ===== hw/rtl/text_console_writer_unit_assert.svh =====
// Assertion macros shared by the console writer modules.
`ifndef TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TCW_ASSERT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define TCW_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// Shared types, codes and constants of the text console writer.
package tcw_pkg;

  localparam int FUNC_W     = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 11;
  localparam int ROW_W      = 5;
  localparam int COL_W      = 7;
  localparam int DATA_W     = 16;
  localparam int ATTR_W     = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 8;

  localparam int COLUMNS_DEFAULT  = 80;
  localparam int ROWS_DEFAULT     = 25;
  localparam int TAB_STOP_DEFAULT = 4;

  localparam logic [FUNC_W-1:0] FUNC_PUT_CHAR   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ_CELL  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_SET_CURSOR = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [ATTR_W-1:0] BLINK_MASK = 8'h7F;
  localparam logic [DATA_W-1:0] CELL_RESET = {ATTR_RESET, CHAR_SPACE};

  localparam logic [CFG_IDX_W-1:0] REG_TEXT_ATTRIBUTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_ENABLED  = 1'd1;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [CHAR_W-1:0] char_code;
    logic [IDX_W-1:0]  cell_index;
    logic [ROW_W-1:0]  new_row;
    logic [COL_W-1:0]  new_column;
  } req_t;

  typedef struct packed {
    logic [IDX_W-1:0]  cursor_index;
    logic [ROW_W-1:0]  cursor_row;
    logic [COL_W-1:0]  cursor_column;
    logic [DATA_W-1:0] cell_data;
    logic              range_error;
  } rsp_t;

  typedef enum logic [1:0] {
    KIND_QUICK,
    KIND_READ,
    KIND_SCROLL
  } item_kind_e;

  typedef enum logic [2:0] {
    MOP_IDLE,
    MOP_CLEAR,
    MOP_PRIME,
    MOP_COPY,
    MOP_BLANK
  } mem_op_e;

  typedef struct packed {
    logic    accept;
    mem_op_e mem_op;
    logic    ptr_clr;
    logic    ptr_inc;
    logic    load_data;
  } cmd_t;

  typedef struct packed {
    item_kind_e kind;
    logic       ptr_copy_last;
    logic       ptr_last;
  } sts_t;

endpackage

// ===== hw/rtl/tcw_stream_if.sv =====
// Valid/ready stream channel carrying one payload word per handshake.
interface tcw_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/text_console_writer_unit.sv =====
// Text console writer top level: controller, datapath and channel ports.
// Cursor moves, set-position, unread cells and ordinary characters give their word in the
// cycle after acceptance; a cell read goes through the read state, a scroll through prime, copy and blank.
// Throughput: one item per cycle outside reads and scrolls, while the result word is not held back.
// Reset: cursor and configuration registers reset at once; a clearing pass then fills
// the store with blank cells before the first item is taken.
module text_console_writer_unit #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS     = tcw_pkg::ROWS_DEFAULT,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  tcw_stream_if.sink                     req_i,
  tcw_stream_if.source                   rsp_o
);

  // The controller and the datapath talk only through these two structs.
  tcw_pkg::cmd_t cmd;
  tcw_pkg::sts_t sts;
  tcw_pkg::rsp_t rsp;

  // The controller owns both handshakes. It holds the request channel off
  // during the clearing pass and while a read or a scroll is in flight, and
  // it takes a new word whenever the result register is empty or is being
  // drained in the same cycle.
  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath holds the cursor, the attribute registers and the screen
  // store. A scroll is done as a row-offset copy through the store's read and
  // write ports, followed by a blank fill of the bottom line.
  tcw_datapath #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req_i.payload),
    .rsp_o       (rsp),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // The result word is built from registers that only change when a request
  // word is accepted or a read result is loaded, so it stays stable while the word waits.
  assign rsp_o.payload = rsp;

endmodule

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine: handshakes, clearing pass, scroll and read sequencing.
`include "text_console_writer_unit_assert.svh"

module tcw_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_ready_o,
  output logic          rsp_valid_o,
  input  logic          rsp_ready_i,
  input  tcw_pkg::sts_t sts_i,
  output tcw_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_PRIME,
    ST_COPY,
    ST_BLANK
  } state_e;

  state_e        state_q, state_d;
  logic          rsp_valid_q, rsp_valid_d;
  logic          accept;
  tcw_pkg::cmd_t cmd;

  assign req_ready_o = (state_q == ST_IDLE) && (!rsp_valid_q || rsp_ready_i);
  assign accept      = req_valid_i && req_ready_o;
  assign rsp_valid_o = rsp_valid_q;
  assign cmd_o       = cmd;

  always_comb begin
    state_d       = state_q;
    rsp_valid_d   = rsp_valid_q && !rsp_ready_i;
    cmd           = '0;
    cmd.mem_op    = tcw_pkg::MOP_IDLE;
    cmd.accept    = accept;
    case (state_q)
      ST_CLEAR: begin
        cmd.mem_op = tcw_pkg::MOP_CLEAR;
        if (sts_i.ptr_last) begin
          cmd.ptr_clr = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (sts_i.kind)
            tcw_pkg::KIND_READ:   state_d = ST_READ;
            tcw_pkg::KIND_SCROLL: state_d = ST_PRIME;
            default:              rsp_valid_d = 1'b1;
          endcase
        end
      end
      ST_READ: begin
        cmd.load_data = 1'b1;
        rsp_valid_d   = 1'b1;
        state_d       = ST_IDLE;
      end
      ST_PRIME: begin
        cmd.mem_op = tcw_pkg::MOP_PRIME;
        state_d    = ST_COPY;
      end
      ST_COPY: begin
        cmd.mem_op  = tcw_pkg::MOP_COPY;
        cmd.ptr_inc = 1'b1;
        if (sts_i.ptr_copy_last) begin
          state_d = ST_BLANK;
        end
      end
      ST_BLANK: begin
        cmd.mem_op = tcw_pkg::MOP_BLANK;
        if (sts_i.ptr_last) begin
          cmd.ptr_clr = 1'b1;
          rsp_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
        end
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // A result is only ever pending while the controller sits idle.
  `TCW_ASSERT(busy_no_result, clk_i, rst_ni, state_q != ST_IDLE, !rsp_valid_q, "result pending while busy")
  `TCW_ASSERT_NEXT(scroll_starts, clk_i, rst_ni, accept && (sts_i.kind == tcw_pkg::KIND_SCROLL), state_q == ST_PRIME, "scroll did not start")
  `TCW_ASSERT_NEXT(copy_to_blank, clk_i, rst_ni, (state_q == ST_COPY) && sts_i.ptr_copy_last, state_q == ST_BLANK, "copy did not hand over to blank fill")

endmodule

// ===== hw/rtl/tcw_datapath.sv =====
// Datapath: cursor, configuration registers, screen store and result registers.
`include "text_console_writer_unit_assert.svh"

module tcw_datapath #(
  parameter int COLUMNS  = tcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS     = tcw_pkg::ROWS_DEFAULT,
  parameter int TAB_STOP = tcw_pkg::TAB_STOP_DEFAULT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  tcw_pkg::req_t                    req_i,
  output tcw_pkg::rsp_t                    rsp_o,
  input  tcw_pkg::cmd_t                    cmd_i,
  output tcw_pkg::sts_t                    sts_o
);

  localparam int Cells    = COLUMNS * ROWS;
  localparam int AddrW    = $clog2(Cells);
  localparam int TabW     = $clog2(COLUMNS + TAB_STOP + 1);
  localparam int RowAdvW  = $clog2(ROWS + 1);
  localparam int NumStops = COLUMNS / TAB_STOP + 1;

  localparam logic [AddrW-1:0]   RowStep  = AddrW'(COLUMNS);
  localparam logic [AddrW-1:0]   CopyStep = AddrW'(COLUMNS + 1);
  localparam logic [AddrW-1:0]   CopyLast = AddrW'(Cells - COLUMNS - 1);
  localparam logic [AddrW-1:0]   CellLast = AddrW'(Cells - 1);
  localparam logic [TabW-1:0]    ColEnd   = TabW'(COLUMNS);
  localparam logic [RowAdvW-1:0] RowEnd   = RowAdvW'(ROWS);

  logic [tcw_pkg::ROW_W-1:0]  row_q;
  logic [tcw_pkg::COL_W-1:0]  col_q;
  logic [tcw_pkg::ATTR_W-1:0] attr_q;
  logic                       blink_q;
  logic [AddrW-1:0]           ptr_q;
  logic [tcw_pkg::DATA_W-1:0] rd_q;
  logic [tcw_pkg::DATA_W-1:0] cell_data_q;
  logic                       range_err_q;
  logic [tcw_pkg::DATA_W-1:0] mem_q [Cells];

  logic [tcw_pkg::ATTR_W-1:0] live_attr;
  logic [AddrW-1:0]           cur_addr;
  logic                       is_put, is_read, is_set, is_special;
  logic                       cell_in_range, set_bad;
  logic [TabW-1:0]            col_base, col_adv, tab_next;
  logic [RowAdvW-1:0]         row_base, row_adv;
  logic                       need_scroll;
  logic                       wr_en, rd_en;
  logic [AddrW-1:0]           wr_addr, rd_addr;
  logic [tcw_pkg::DATA_W-1:0] wr_data;
  tcw_pkg::item_kind_e        kind;

  assign live_attr = blink_q ? attr_q : (attr_q & tcw_pkg::BLINK_MASK);
  assign cur_addr  = AddrW'(32'(row_q) * COLUMNS + 32'(col_q));

  assign is_put     = (req_i.func == tcw_pkg::FUNC_PUT_CHAR);
  assign is_read    = (req_i.func == tcw_pkg::FUNC_READ_CELL);
  assign is_set     = (req_i.func == tcw_pkg::FUNC_SET_CURSOR);
  assign is_special = (req_i.char_code == tcw_pkg::CHAR_CR) ||
                      (req_i.char_code == tcw_pkg::CHAR_LF) ||
                      (req_i.char_code == tcw_pkg::CHAR_TAB);
  assign cell_in_range = (32'(req_i.cell_index) < 32'(Cells));
  assign set_bad       = (32'(req_i.new_row) >= 32'(ROWS)) ||
                         (32'(req_i.new_column) >= 32'(COLUMNS));

  assign col_base = TabW'(col_q);
  assign row_base = RowAdvW'(row_q);

  // Next tab stop: the smallest multiple of the stop width above the column.
  always_comb begin
    tab_next = ColEnd;
    for (int k = NumStops; k >= 1; k--) begin
      if (TabW'(k * TAB_STOP) > col_base) begin
        tab_next = TabW'(k * TAB_STOP);
      end
    end
  end

  always_comb begin
    row_adv = row_base;
    col_adv = col_base;
    if (req_i.char_code == tcw_pkg::CHAR_CR) begin
      col_adv = '0;
    end else if (req_i.char_code == tcw_pkg::CHAR_LF) begin
      row_adv = row_base + RowAdvW'(1);
    end else if (req_i.char_code == tcw_pkg::CHAR_TAB) begin
      col_adv = tab_next;
    end else begin
      col_adv = col_base + TabW'(1);
    end
    if (col_adv >= ColEnd) begin
      row_adv = row_adv + RowAdvW'(1);
      col_adv = '0;
    end
  end

  assign need_scroll = (row_adv >= RowEnd);

  always_comb begin
    if (is_put && need_scroll) begin
      kind = tcw_pkg::KIND_SCROLL;
    end else if (is_read && cell_in_range) begin
      kind = tcw_pkg::KIND_READ;
    end else begin
      kind = tcw_pkg::KIND_QUICK;
    end
  end

  // Store write port: character writes, reset fill, scroll copy and blank fill.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = ptr_q;
    wr_data = rd_q;
    if (cmd_i.accept && is_put && !is_special) begin
      wr_en   = 1'b1;
      wr_addr = cur_addr;
      wr_data = {live_attr, req_i.char_code};
    end
    case (cmd_i.mem_op)
      tcw_pkg::MOP_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = tcw_pkg::CELL_RESET;
      end
      tcw_pkg::MOP_COPY: wr_en = 1'b1;
      tcw_pkg::MOP_BLANK: begin
        wr_en   = 1'b1;
        wr_data = {live_attr, tcw_pkg::CHAR_SPACE};
      end
      default: ;
    endcase
  end

  // Store read port: the copy reads one row ahead of the write pointer.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr_q + RowStep;
    if (cmd_i.accept && is_read && cell_in_range) begin
      rd_en   = 1'b1;
      rd_addr = AddrW'(req_i.cell_index);
    end
    case (cmd_i.mem_op)
      tcw_pkg::MOP_PRIME: rd_en = 1'b1;
      tcw_pkg::MOP_COPY: begin
        rd_en   = (ptr_q != CopyLast);
        rd_addr = ptr_q + CopyStep;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      attr_q  <= tcw_pkg::ATTR_RESET;
      blink_q <= 1'b0;
      ptr_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tcw_pkg::REG_TEXT_ATTRIBUTE: attr_q  <= cfg_wdata_i;
          tcw_pkg::REG_BLINK_ENABLED:  blink_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.ptr_clr) begin
        ptr_q <= '0;
      end else if (cmd_i.ptr_inc) begin
        ptr_q <= ptr_q + AddrW'(1);
      end
      if (cmd_i.accept) begin
        if (is_put) begin
          if (need_scroll) begin
            row_q <= tcw_pkg::ROW_W'(ROWS - 1);
            col_q <= '0;
          end else begin
            row_q <= tcw_pkg::ROW_W'(row_adv);
            col_q <= tcw_pkg::COL_W'(col_adv);
          end
        end else if (is_set && !set_bad) begin
          row_q <= req_i.new_row;
          col_q <= req_i.new_column;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cell_data_q <= '0;
      range_err_q <= is_set && set_bad;
    end else if (cmd_i.load_data) begin
      cell_data_q <= rd_q;
    end
  end

  assign rsp_o.cursor_index  = tcw_pkg::IDX_W'(cur_addr);
  assign rsp_o.cursor_row    = row_q;
  assign rsp_o.cursor_column = col_q;
  assign rsp_o.cell_data     = cell_data_q;
  assign rsp_o.range_error   = range_err_q;

  assign sts_o.kind          = kind;
  assign sts_o.ptr_copy_last = (ptr_q == CopyLast);
  assign sts_o.ptr_last      = (ptr_q == CellLast);

  `TCW_ASSERT(cursor_on_screen, clk_i, rst_ni, 1'b1, (32'(row_q) < 32'(ROWS)) && (32'(col_q) < 32'(COLUMNS)), "cursor left the screen")

endmodule
